FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects signals named clock and reset
// in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OGA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OGA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: design/ogacc_pkg.sv
package ogacc_pkg;

   // Width of the register bus address.
   localparam int CSR_AW = 5;

   // Q1.16 unity and the Q0.32 decay factor for successive exp table entries.
   localparam logic [16:0] ONE_Q16        = 17'd65536;
   localparam logic [31:0] EXP_FACTOR_Q32 = 32'd4260744631;

   // Operation codes of an input transaction.
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [1:0] {
      STAT_UPDATED = 2'd0,
      STAT_CLIPPED = 2'd1,
      STAT_OUTSIDE = 2'd2,
      STAT_READ    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OCC_UNKNOWN  = 2'd0,
      OCC_FREE     = 2'd1,
      OCC_OCCUPIED = 2'd2
   } occ_type;

   typedef enum logic [2:0] {
      REG_CELLS_PER_MM  = 3'd0,
      REG_CLIP_HIGH     = 3'd1,
      REG_CLIP_LOW      = 3'd2,
      REG_NORMAL_WEIGHT = 3'd3,
      REG_SCORE_THRESH  = 3'd4,
      REG_OCC_THRESH    = 3'd5,
      REG_POSE_HEIGHT   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [15:0]        cells_per_mm;
      logic signed [15:0] clip_high;
      logic signed [15:0] clip_low;
      logic [16:0]        normal_weight;
      logic [16:0]        score_threshold;
      logic [3:0]         occupied_threshold;
      logic signed [15:0] pose_height;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep;
      logic capture;
      logic stage_a;
      logic stage_b;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
   } dp_sts_type;

   // Occupancy class of a cell from its known mark and counter.
   function automatic occ_type occ_of(input logic known, input logic [3:0] cnt,
                                      input logic [3:0] thresh);
      occ_type occ;
      if (!known) begin
         occ = OCC_UNKNOWN;
      end else if (cnt > thresh) begin
         occ = OCC_OCCUPIED;
      end else begin
         occ = OCC_FREE;
      end
      return occ;
   endfunction

endpackage

FILE: design/ogacc_if.sv
// Point or read request channel.
interface ogacc_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [15:0] cam_x;
   logic signed [15:0] cam_y;
   logic signed [15:0] cam_z;
   logic signed [15:0] normal_comp;
   logic [15:0]        read_index;

   modport source (output valid, op, cam_x, cam_y, cam_z, normal_comp, read_index,
                   input ready);
   modport sink   (input valid, op, cam_x, cam_y, cam_z, normal_comp, read_index,
                   output ready);
endinterface

// Result channel.
interface ogacc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] cell_index;
   logic [3:0]  hit_count;
   logic [1:0]  occupancy;

   modport source (output valid, status, cell_index, hit_count, occupancy, input ready);
   modport sink   (input valid, status, cell_index, hit_count, occupancy, output ready);
endinterface

FILE: design/ogacc_csr.sv
module ogacc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ogacc_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output ogacc_pkg::cfg_type            cfg
);
   import ogacc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type sel_index;
   logic          wr_en;

   assign pready    = 1'b1;
   assign sel_index = reg_index_type'(paddr[CSR_AW-1:2]);
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel_index)
            REG_CELLS_PER_MM:  cfg_in.cells_per_mm       = pwdata[15:0];
            REG_CLIP_HIGH:     cfg_in.clip_high          = pwdata[15:0];
            REG_CLIP_LOW:      cfg_in.clip_low           = pwdata[15:0];
            REG_NORMAL_WEIGHT: cfg_in.normal_weight      = pwdata[16:0];
            REG_SCORE_THRESH:  cfg_in.score_threshold    = pwdata[16:0];
            REG_OCC_THRESH:    cfg_in.occupied_threshold = pwdata[3:0];
            REG_POSE_HEIGHT:   cfg_in.pose_height        = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_per_mm       <= 16'd655;
         cfg_ff.clip_high          <= 16'sd3000;
         cfg_ff.clip_low           <= -16'sd500;
         cfg_ff.normal_weight      <= 17'd32768;
         cfg_ff.score_threshold    <= 17'd19661;
         cfg_ff.occupied_threshold <= 4'd5;
         cfg_ff.pose_height        <= 16'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux.
   always_comb begin
      case (sel_index)
         REG_CELLS_PER_MM:  prdata = {16'd0, cfg_ff.cells_per_mm};
         REG_CLIP_HIGH:     prdata = {16'd0, cfg_ff.clip_high};
         REG_CLIP_LOW:      prdata = {16'd0, cfg_ff.clip_low};
         REG_NORMAL_WEIGHT: prdata = {15'd0, cfg_ff.normal_weight};
         REG_SCORE_THRESH:  prdata = {15'd0, cfg_ff.score_threshold};
         REG_OCC_THRESH:    prdata = {28'd0, cfg_ff.occupied_threshold};
         REG_POSE_HEIGHT:   prdata = {16'd0, cfg_ff.pose_height};
         default:           prdata = 32'd0;
      endcase
   end

endmodule

FILE: design/ogacc_ctrl.sv
`include "assert_macros.svh"

module ogacc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     rsp_ready,
   input  ogacc_pkg::dp_sts_type    sts,
   output ogacc_pkg::ctrl_cmd_type  cmd,
   output logic                     req_ready,
   output logic                     rsp_valid
);
   import ogacc_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A,
      ST_B,
      ST_C
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_A;
            end
         end
         ST_A: begin
            cmd.stage_a = 1'b1;
            state_in    = ST_B;
         end
         ST_B: begin
            cmd.stage_b = 1'b1;
            state_in    = ST_C;
         end
         ST_C: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The result register is full from commit until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `OGA_ASSERT_NXT(a_capture_enters_a, cmd.capture, state_ff == ST_A)
   `OGA_ASSERT_IMP(a_ready_only_idle, req_ready_ff, state_ff == ST_IDLE)
   `OGA_ASSERT_NXT(a_commit_fills_rsp, cmd.commit, rsp_valid_ff)
   `OGA_ASSERT_IMP(a_no_rsp_in_sweep, cmd.sweep, !rsp_valid_ff)

endmodule

FILE: design/ogacc_dp.sv
module ogacc_dp #(
   parameter int GRID_SIDE   = 256,
   parameter int EXP_ENTRIES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ogacc_pkg::ctrl_cmd_type  cmd,
   output ogacc_pkg::dp_sts_type    sts,
   input  ogacc_pkg::cfg_type       cfg,
   input  logic                     in_op,
   input  logic signed [15:0]       in_cam_x,
   input  logic signed [15:0]       in_cam_y,
   input  logic signed [15:0]       in_cam_z,
   input  logic signed [15:0]       in_normal_comp,
   input  logic [15:0]              in_read_index,
   output logic [1:0]               out_status,
   output logic [15:0]              out_cell_index,
   output logic [3:0]               out_hit_count,
   output logic [1:0]               out_occupancy
);
   import ogacc_pkg::*;

   localparam int          CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int          CW        = $clog2(CELLS);
   localparam int          GW        = $clog2(GRID_SIDE);
   localparam int          EW        = $clog2(EXP_ENTRIES);
   localparam int          SWEEP_N   = (CELLS > EXP_ENTRIES) ? CELLS : EXP_ENTRIES;
   localparam int          SW        = $clog2(SWEEP_N);
   localparam logic [31:0] CELLS_U   = 32'(CELLS);
   localparam logic [31:0] EXP_U     = 32'(EXP_ENTRIES);
   localparam logic [31:0] SWEEP_TOP = 32'(SWEEP_N - 1);

   // Memories: exp table (Q1.16) and {known, counter} per cell.
   logic [16:0] exp_mem [EXP_ENTRIES];
   logic [4:0]  cell_mem [CELLS];

   // Sweep after reset: clears the cells and builds the exp table.
   logic [SW-1:0] sweep_ff;
   logic [31:0]   acc_ff;
   logic [31:0]   acc_in;
   logic [63:0]   acc_prod;
   logic [32:0]   acc_round;
   logic [16:0]   exp_entry;
   logic          sweep_first;

   assign sweep_first    = (sweep_ff == '0);
   assign sts.sweep_last = (32'(sweep_ff) == SWEEP_TOP);
   assign acc_prod       = 64'(acc_ff) * 64'(EXP_FACTOR_Q32);
   assign acc_in         = sweep_first ? EXP_FACTOR_Q32 : acc_prod[63:32];
   assign acc_round      = 33'(acc_ff) + 33'd32768;
   assign exp_entry      = sweep_first ? ONE_Q16 : {1'b0, acc_round[31:16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep && !sts.sweep_last) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         acc_ff <= acc_in;
      end
   end

   // Captured transaction.
   logic               op_ff;
   logic signed [15:0] cam_x_ff;
   logic signed [15:0] cam_y_ff;
   logic signed [15:0] cam_z_ff;
   logic signed [15:0] normal_ff;
   logic [15:0]        read_index_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= in_op;
         cam_x_ff      <= in_cam_x;
         cam_y_ff      <= in_cam_y;
         cam_z_ff      <= in_cam_z;
         normal_ff     <= in_normal_comp;
         read_index_ff <= in_read_index;
      end
   end

   // Stage A: axis remap, height clip, normal term, exp index, grid scaling.
   logic signed [16:0] hgt;
   logic signed [16:0] fwd;
   logic signed [16:0] lat;
   logic signed [16:0] n_ext;
   logic [16:0]        nabs;
   logic [16:0]        part_n;
   logic signed [17:0] dh;
   logic [17:0]        dabs;
   logic [14:0]        idx_wide;
   logic [EW-1:0]      tab_addr;
   logic [16:0]        fabs;
   logic [16:0]        labs;
   logic [32:0]        fprod;
   logic [32:0]        lprod;
   logic               clip;

   assign hgt      = -17'(cam_y_ff);
   assign fwd      = 17'(cam_z_ff);
   assign lat      = -17'(cam_x_ff);
   assign n_ext    = 17'(normal_ff);
   assign clip     = (hgt > 17'(cfg.clip_high)) || (hgt < 17'(cfg.clip_low));
   assign nabs     = (n_ext < 0) ? 17'(-n_ext) : 17'(n_ext);
   assign part_n   = ONE_Q16 - {nabs[15:0], 1'b0};
   assign dh       = 18'(hgt) - 18'(cfg.pose_height);
   assign dabs     = (dh < 0) ? 18'(-dh) : 18'(dh);
   assign idx_wide = dabs[17:3];
   assign tab_addr = (32'(idx_wide) >= EXP_U) ? EW'(EXP_ENTRIES - 1) : idx_wide[EW-1:0];
   assign fabs     = (fwd < 0) ? 17'(-fwd) : 17'(fwd);
   assign labs     = (lat < 0) ? 17'(-lat) : 17'(lat);
   assign fprod    = 33'(fabs) * 33'(cfg.cells_per_mm);
   assign lprod    = 33'(labs) * 33'(cfg.cells_per_mm);

   logic        clip_ff;
   logic [16:0] part_n_ff;
   logic        fneg_ff;
   logic        lneg_ff;
   logic [15:0] fmag_ff;
   logic [15:0] lmag_ff;
   logic [16:0] tab_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.stage_a) begin
         clip_ff   <= clip;
         part_n_ff <= part_n;
         fneg_ff   <= (fwd < 0);
         lneg_ff   <= (lat < 0);
         fmag_ff   <= fprod[31:16];
         lmag_ff   <= lprod[31:16];
         tab_rd_ff <= exp_mem[tab_addr];
      end
      if (cmd.sweep && (32'(sweep_ff) < EXP_U)) begin
         exp_mem[sweep_ff[EW-1:0]] <= exp_entry;
      end
   end

   // Stage B: score products, grid cell, cell read.
   logic [16:0]        part_z;
   logic [16:0]        sigma;
   logic [33:0]        p1;
   logic [33:0]        p2;
   logic signed [17:0] gx_mag;
   logic signed [17:0] gy_mag;
   logic signed [17:0] gx;
   logic signed [17:0] gy;
   logic               outside;
   logic [31:0]        lin_addr;
   logic [CW-1:0]      rd_addr;

   assign part_z   = ONE_Q16 - tab_rd_ff;
   assign sigma    = (cfg.normal_weight > ONE_Q16) ? ONE_Q16 : cfg.normal_weight;
   assign p1       = 34'(sigma) * 34'(part_n_ff);
   assign p2       = 34'(ONE_Q16 - sigma) * 34'(part_z);
   assign gx_mag   = $signed({2'b00, fmag_ff});
   assign gy_mag   = $signed({2'b00, lmag_ff});
   assign gx       = (fneg_ff ? -gx_mag : gx_mag) + $signed(18'(GRID_SIDE / 2));
   assign gy       = (lneg_ff ? -gy_mag : gy_mag) + $signed(18'(GRID_SIDE / 2));
   assign outside  = (gx < 0) || (gx >= $signed(18'(GRID_SIDE)))
                  || (gy < 0) || (gy >= $signed(18'(GRID_SIDE)));
   assign lin_addr = 32'(gy[GW-1:0]) * 32'(GRID_SIDE) + 32'(gx[GW-1:0]);
   assign rd_addr  = (op_ff == OP_READ) ? CW'(read_index_ff) : lin_addr[CW-1:0];

   logic [33:0]   p1_ff;
   logic [33:0]   p2_ff;
   logic          outside_ff;
   logic          beyond_ff;
   logic [CW-1:0] addr_ff;
   logic [4:0]    cell_rd_ff;

   // Stage C: score compare, counter update, result.
   logic [34:0] sum;
   logic [18:0] score;
   logic        hit;
   logic        known;
   logic [3:0]  cnt;
   logic [3:0]  new_cnt;
   logic        upd_we;
   logic        cell_we;
   logic [CW-1:0] cell_waddr;
   logic [4:0]  cell_wdata;

   assign sum   = 35'(p1_ff) + 35'(p2_ff) + 35'd32768;
   assign score = sum[34:16];
   assign hit   = (score >= 19'(cfg.score_threshold));
   assign known = cell_rd_ff[4];
   assign cnt   = cell_rd_ff[3:0];

   always_comb begin
      if (!known) begin
         new_cnt = hit ? 4'd1 : 4'd0;
      end else if (hit) begin
         new_cnt = (cnt >= 4'd13) ? 4'd15 : cnt + 4'd2;
      end else begin
         new_cnt = (cnt == 4'd0) ? 4'd0 : cnt - 4'd1;
      end
   end

   assign upd_we     = cmd.commit && (op_ff == OP_ADD) && !clip_ff && !outside_ff;
   assign cell_we    = upd_we || (cmd.sweep && (32'(sweep_ff) < CELLS_U));
   assign cell_waddr = cmd.sweep ? sweep_ff[CW-1:0] : addr_ff;
   assign cell_wdata = cmd.sweep ? 5'd0 : {1'b1, new_cnt};

   always_ff @(posedge clock) begin
      if (cmd.stage_b) begin
         p1_ff      <= p1;
         p2_ff      <= p2;
         outside_ff <= outside;
         beyond_ff  <= (32'(read_index_ff) >= CELLS_U);
         addr_ff    <= rd_addr;
         cell_rd_ff <= cell_mem[rd_addr];
      end
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
   end

   // Result register.
   status_type  status_in;
   logic [15:0] index_in;
   logic [3:0]  count_in;
   occ_type     occ_in;
   status_type  status_ff;
   logic [15:0] index_ff;
   logic [3:0]  count_ff;
   occ_type     occ_ff;

   always_comb begin
      status_in = STAT_UPDATED;
      index_in  = 16'd0;
      count_in  = 4'd0;
      occ_in    = OCC_UNKNOWN;
      if (op_ff == OP_READ) begin
         index_in = read_index_ff;
         if (beyond_ff) begin
            status_in = STAT_OUTSIDE;
         end else begin
            status_in = STAT_READ;
            count_in  = cnt;
            occ_in    = occ_of(known, cnt, cfg.occupied_threshold);
         end
      end else if (clip_ff) begin
         status_in = STAT_CLIPPED;
      end else if (outside_ff) begin
         status_in = STAT_OUTSIDE;
      end else begin
         index_in = 16'(addr_ff);
         count_in = new_cnt;
         occ_in   = occ_of(1'b1, new_cnt, cfg.occupied_threshold);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         count_ff  <= count_in;
         occ_ff    <= occ_in;
      end
   end

   assign out_status     = status_ff;
   assign out_cell_index = index_ff;
   assign out_hit_count  = count_ff;
   assign out_occupancy  = occ_ff;

endmodule

FILE: design/occupancy_grid_accumulator.sv
// Flow: an accepted request transaction is captured, then the controller steps it through
// the exp table read, the score multipliers and the cell read-modify-write; its response
// is registered at commit, and no new request is taken until then. Commit waits while an
// earlier response is still held. Reset: synchronous; afterwards a clearing pass zeroes
// the cell store and builds the exp table, with no request accepted until it ends;
// registers with a reset value return to it at once.
module occupancy_grid_accumulator #(
   parameter int GRID_SIDE   = 256,
   parameter int EXP_ENTRIES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   ogacc_req_if.sink                     req_chan,
   ogacc_rsp_if.source                   rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ogacc_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import ogacc_pkg::*;

   cfg_type      cfg;
   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   // Register file.
   ogacc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer.
   ogacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid)
   );

   // Arithmetic, tables and cell store.
   ogacc_dp #(
      .GRID_SIDE   (GRID_SIDE),
      .EXP_ENTRIES (EXP_ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .cfg            (cfg),
      .in_op          (req_chan.op),
      .in_cam_x       (req_chan.cam_x),
      .in_cam_y       (req_chan.cam_y),
      .in_cam_z       (req_chan.cam_z),
      .in_normal_comp (req_chan.normal_comp),
      .in_read_index  (req_chan.read_index),
      .out_status     (rsp_chan.status),
      .out_cell_index (rsp_chan.cell_index),
      .out_hit_count  (rsp_chan.hit_count),
      .out_occupancy  (rsp_chan.occupancy)
   );

endmodule
